// ===== design/cta_pkg.sv =====
`timescale 1ns / 1ps

package cta_pkg;

  // character codes
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // fixed field widths
  localparam int OUT_BITS  = 32;
  localparam int SPAN_BITS = 32;
  localparam int TDATA_BITS = 136;

  // reset values of the start and end registers
  localparam logic [31:0] CFG_COORD_RST = 32'd1;

  // output queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_M    = 2'd1,
    OP_D    = 2'd2,
    OP_I    = 2'd3
  } cta_op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SYNTAX = 2'd1,
    ST_SPAN   = 2'd2,
    ST_OVF    = 2'd3
  } cta_st_t;

  typedef enum logic [1:0] {
    AT_NONE    = 2'd0,
    AT_DNA_DNA = 2'd1,
    AT_PEP_DNA = 2'd2,
    AT_DNA_PEP = 2'd3
  } cta_at_t;

  // spaced-form parser phases
  typedef enum logic [3:0] {
    PH_OP   = 4'b0001,
    PH_SP1  = 4'b0010,
    PH_CNT  = 4'b0100,
    PH_NEXT = 4'b1000
  } cta_ph_t;

  typedef enum logic [2:0] {
    REG_FORMAT_MODE   = 3'd0,
    REG_REF_START     = 3'd1,
    REG_REF_END       = 3'd2,
    REG_MATCH_START   = 3'd3,
    REG_REF_REVERSE   = 3'd4,
    REG_MATCH_REVERSE = 3'd5
  } cta_reg_t;

  typedef struct packed {
    logic        fmt;
    logic [31:0] ref_start;
    logic [31:0] ref_end;
    logic [31:0] match_start;
    logic        ref_rev;
    logic        match_rev;
  } cta_cfg_t;

  // cursor reload on a start register write
  typedef struct packed {
    logic        ld_ref;
    logic        ld_match;
    logic [31:0] data;
  } cta_ld_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] ref_first;
    logic [OUT_BITS-1:0] ref_last;
    logic [OUT_BITS-1:0] match_first;
    logic [OUT_BITS-1:0] match_last;
  } cta_blk_t;

  // parse stage result
  typedef struct packed {
    logic                 blk_v;
    cta_blk_t             blk;
    logic                 st_v;
    cta_st_t              err;
    logic [SPAN_BITS-1:0] span;
  } cta_fin_t;

  // queue entry: an optional block and an optional status
  typedef struct packed {
    logic     blk_v;
    cta_blk_t blk;
    logic     st_v;
    cta_at_t  align_type;
    cta_st_t  status;
  } cta_rec_t;

  typedef struct packed {
    logic in_v;
    logic fin_v;
  } cta_occ_t;

  function automatic cta_op_t op_code(input logic [7:0] c);
    cta_op_t op;
    op = OP_NONE;
    if (c == CH_M) op = OP_M;
    else if (c == CH_D) op = OP_D;
    else if (c == CH_I) op = OP_I;
    return op;
  endfunction

endpackage

// ===== design/cta_parse.sv =====
`timescale 1ns / 1ps

module cta_parse import cta_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int COUNT_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_acc,
  input  logic [7:0] in_char,
  input  logic     in_last,
  input  cta_cfg_t cfg,
  input  cta_ld_t  ld,
  output cta_fin_t fin_o,
  output cta_occ_t occ_o
);

  localparam logic [COORD_BITS-1:0] START_CUR = COORD_BITS'(signed'(CFG_COORD_RST));

  // input register
  logic       in_v_r;
  logic [7:0] in_char_r;
  logic       in_last_r;

  // string state
  cta_ph_t                ph_r, ph_nxt;
  cta_op_t                pend_r, pend_nxt;
  logic [COUNT_BITS-1:0]  acc_r, acc_nxt;
  logic                   seen_r, seen_nxt;
  cta_st_t                err_r, err_nxt;
  logic [SPAN_BITS-1:0]   span_r, span_nxt;
  logic [COORD_BITS-1:0]  rcur_r, rcur_nxt;
  logic [COORD_BITS-1:0]  mcur_r, mcur_nxt;
  cta_fin_t               fin_r, fin_nxt;

  // decode
  logic                  is_dig;
  logic                  is_sp;
  cta_op_t               ch_op;
  logic [COUNT_BITS+3:0] acc_w;
  logic [COUNT_BITS+3:0] dig_w;
  logic                  dig_ovf;

  // op application
  logic                  go;
  cta_op_t               go_op;
  logic [COUNT_BITS-1:0] go_len;
  logic [COORD_BITS-1:0] len_c;
  logic [SPAN_BITS:0]    sum_w;
  logic [COORD_BITS-1:0] r_adv, r_end, m_adv, m_end;

  assign is_dig  = (in_char_r >= CH_ZERO) && (in_char_r <= CH_NINE);
  assign is_sp   = (in_char_r == CH_SPACE);
  assign ch_op   = op_code(in_char_r);
  assign acc_w   = (COUNT_BITS+4)'(acc_r);
  assign dig_w   = (acc_w << 3) + (acc_w << 1) + (COUNT_BITS+4)'(in_char_r[3:0]);
  assign dig_ovf = |dig_w[COUNT_BITS+3:COUNT_BITS];

  // cursor moves by the op length, block end is one step back
  assign len_c = COORD_BITS'(go_len);
  assign sum_w = {1'b0, span_r} + (SPAN_BITS+1)'(go_len);
  assign r_adv = cfg.ref_rev   ? rcur_r - len_c : rcur_r + len_c;
  assign r_end = cfg.ref_rev   ? rcur_r - len_c + COORD_BITS'(1)
                               : rcur_r + len_c - COORD_BITS'(1);
  assign m_adv = cfg.match_rev ? mcur_r - len_c : mcur_r + len_c;
  assign m_end = cfg.match_rev ? mcur_r - len_c + COORD_BITS'(1)
                               : mcur_r + len_c - COORD_BITS'(1);

  always_comb begin
    ph_nxt   = ph_r;
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    seen_nxt = seen_r;
    err_nxt  = err_r;
    span_nxt = span_r;
    rcur_nxt = rcur_r;
    mcur_nxt = mcur_r;
    go       = 1'b0;
    go_op    = OP_NONE;
    go_len   = '0;
    fin_nxt  = '0;

    if (in_v_r) begin
      // syntax step for this character
      if (err_r == ST_OK) begin
        if (cfg.fmt) begin
          if (is_dig) begin
            if (dig_ovf) begin
              err_nxt = ST_OVF;
            end else begin
              acc_nxt  = dig_w[COUNT_BITS-1:0];
              seen_nxt = 1'b1;
            end
          end else if (ch_op != OP_NONE) begin
            go       = 1'b1;
            go_op    = ch_op;
            go_len   = seen_r ? acc_r : COUNT_BITS'(1);
            acc_nxt  = '0;
            seen_nxt = 1'b0;
          end else begin
            err_nxt = ST_SYNTAX;
          end
        end else begin
          unique case (ph_r)
            PH_OP, PH_NEXT: begin
              if (ch_op != OP_NONE) begin
                pend_nxt = ch_op;
                ph_nxt   = PH_SP1;
              end else if (!(ph_r == PH_NEXT && is_sp)) begin
                err_nxt = ST_SYNTAX;
              end
            end
            PH_SP1: begin
              if (is_sp) ph_nxt = PH_CNT;
              else err_nxt = ST_SYNTAX;
            end
            PH_CNT: begin
              if (is_dig) begin
                if (dig_ovf) begin
                  err_nxt = ST_OVF;
                end else begin
                  acc_nxt  = dig_w[COUNT_BITS-1:0];
                  seen_nxt = 1'b1;
                end
              end else if (is_sp && seen_r) begin
                go       = 1'b1;
                go_op    = pend_r;
                go_len   = acc_r;
                pend_nxt = OP_NONE;
                acc_nxt  = '0;
                seen_nxt = 1'b0;
                ph_nxt   = PH_NEXT;
              end else if (!is_sp) begin
                err_nxt = ST_SYNTAX;
              end
            end
            default: ph_nxt = PH_OP;
          endcase
        end
      end

      // end of string: dangling op or count
      if (in_last_r && err_nxt == ST_OK) begin
        if (cfg.fmt) begin
          if (seen_nxt) err_nxt = ST_SYNTAX;
        end else if (ph_nxt == PH_SP1 || (ph_nxt == PH_CNT && !seen_nxt)) begin
          err_nxt = ST_SYNTAX;
        end else if (ph_nxt == PH_CNT) begin
          go     = 1'b1;
          go_op  = pend_nxt;
          go_len = acc_nxt;
        end
      end

      // apply one op, at most one per character
      if (go) begin
        if ((go_op == OP_M || go_op == OP_D) && sum_w[SPAN_BITS]) begin
          err_nxt = ST_OVF;
        end else begin
          if (go_op == OP_M || go_op == OP_D) span_nxt = sum_w[SPAN_BITS-1:0];
          if (go_op == OP_D) rcur_nxt = r_adv;
          if (go_op == OP_I) mcur_nxt = m_adv;
          if (go_op == OP_M) begin
            rcur_nxt                = r_adv;
            mcur_nxt                = m_adv;
            fin_nxt.blk_v           = 1'b1;
            fin_nxt.blk.ref_first   = OUT_BITS'(rcur_r);
            fin_nxt.blk.ref_last    = OUT_BITS'(r_end);
            fin_nxt.blk.match_first = OUT_BITS'(mcur_r);
            fin_nxt.blk.match_last  = OUT_BITS'(m_end);
          end
        end
      end

      // status item and string restart
      if (in_last_r) begin
        fin_nxt.st_v = 1'b1;
        fin_nxt.err  = err_nxt;
        fin_nxt.span = span_nxt;
        ph_nxt   = PH_OP;
        pend_nxt = OP_NONE;
        acc_nxt  = '0;
        seen_nxt = 1'b0;
        err_nxt  = ST_OK;
        span_nxt = '0;
        rcur_nxt = COORD_BITS'(signed'(cfg.ref_start));
        mcur_nxt = COORD_BITS'(signed'(cfg.match_start));
      end
    end

    // start register writes reload the cursors
    if (ld.ld_ref)   rcur_nxt = COORD_BITS'(signed'(ld.data));
    if (ld.ld_match) mcur_nxt = COORD_BITS'(signed'(ld.data));
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      ph_r        <= PH_OP;
      pend_r      <= OP_NONE;
      acc_r       <= '0;
      seen_r      <= 1'b0;
      err_r       <= ST_OK;
      span_r      <= '0;
      rcur_r      <= START_CUR;
      mcur_r      <= START_CUR;
      fin_r.blk_v <= 1'b0;
      fin_r.st_v  <= 1'b0;
    end else begin
      in_v_r <= in_acc;
      ph_r   <= ph_nxt;
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
      seen_r <= seen_nxt;
      err_r  <= err_nxt;
      span_r <= span_nxt;
      rcur_r <= rcur_nxt;
      mcur_r <= mcur_nxt;
      fin_r  <= fin_nxt;
    end
  end

  // input payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_char_r <= in_char;
      in_last_r <= in_last;
    end
  end

  assign fin_o       = fin_r;
  assign occ_o.in_v  = in_v_r;
  assign occ_o.fin_v = fin_r.blk_v | fin_r.st_v;

  // a string end always leaves clean state behind
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && in_last_r) |=> (fin_r.st_v && err_r == ST_OK && span_r == '0))
    else $error("string end did not clear parse state");

  // once an error is latched no block may follow
  a_err_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK) |=> !fin_r.blk_v)
    else $error("block produced after an error");

endmodule

// ===== design/cta_final.sv =====
`timescale 1ns / 1ps

module cta_final import cta_pkg::*; (
  input  logic     clk,
  input  cta_cfg_t cfg,
  input  cta_fin_t fin,
  output logic     push,
  output cta_rec_t rec
);

  // reference span |end - start| + 1 and its x3 window, from config
  logic signed [32:0] s_w, e_w;
  logic        [32:0] diff_w;
  logic        [32:0] rl_r, rl_nxt;
  logic        [34:0] rl3_r, rl3_nxt;
  logic        [34:0] rl3p2_r, rl3p2_nxt;

  // span checks
  logic [33:0] span3;
  logic        eq_dd, eq_pd, eq_dp;

  assign s_w       = {cfg.ref_start[31], cfg.ref_start};
  assign e_w       = {cfg.ref_end[31], cfg.ref_end};
  assign diff_w    = (s_w < e_w) ? 33'(e_w - s_w) : 33'(s_w - e_w);
  assign rl_nxt    = diff_w + 33'd1;
  assign rl3_nxt   = (35'(rl_r) << 1) + 35'(rl_r);
  assign rl3p2_nxt = (35'(rl_r) << 1) + 35'(rl_r) + 35'd2;

  always_ff @(posedge clk) begin
    rl_r    <= rl_nxt;
    rl3_r   <= rl3_nxt;
    rl3p2_r <= rl3p2_nxt;
  end

  // span / 3 == rl is the same as 3*rl <= span <= 3*rl + 2
  assign span3 = (34'(fin.span) << 1) + 34'(fin.span);
  assign eq_dd = (33'(fin.span) == rl_r);
  assign eq_pd = (span3 == 34'(rl_r));
  assign eq_dp = (35'(fin.span) >= rl3_r) && (35'(fin.span) <= rl3p2_r);

  always_comb begin
    rec.blk_v      = fin.blk_v;
    rec.blk        = fin.blk;
    rec.st_v       = fin.st_v;
    rec.align_type = AT_NONE;
    rec.status     = fin.err;
    if (fin.err == ST_OK) begin
      priority if (eq_dd) rec.align_type = AT_DNA_DNA;
      else if (eq_pd)     rec.align_type = AT_PEP_DNA;
      else if (eq_dp)     rec.align_type = AT_DNA_PEP;
      else                rec.status     = ST_SPAN;
    end
  end

  assign push = fin.blk_v | fin.st_v;

endmodule

// ===== design/cta_outq.sv =====
`timescale 1ns / 1ps

module cta_outq import cta_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  cta_rec_t              rec,
  output logic [Q_CNT_W-1:0]    cnt,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_BITS-1:0] out_tdata,  // ref_first, ref_last, match_first,
                                            // match_last, align_type, status, pad
  output logic                  out_tuser,  // item_kind
  output logic                  out_tlast   // last_result
);

  cta_rec_t            q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                half_r, half_nxt;

  cta_rec_t  head;
  logic      sel_st;
  logic      take;
  logic      pop;
  cta_blk_t  blk_o;
  cta_at_t   at_o;
  cta_st_t   st_o;

  // head entry gives its block first, then its status
  assign head   = q_r[rd_ptr_r];
  assign sel_st = !(head.blk_v && !half_r);
  assign take   = out_tvalid && out_tready;
  assign pop    = take && (sel_st || !head.st_v);

  assign blk_o = sel_st ? '0 : head.blk;
  assign at_o  = sel_st ? head.align_type : AT_NONE;
  assign st_o  = sel_st ? head.status : ST_OK;

  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = sel_st;
  assign out_tlast  = sel_st;
  assign out_tdata  = {4'b0, st_o, at_o, blk_o.match_last, blk_o.match_first,
                       blk_o.ref_last, blk_o.ref_first};

  always_comb begin
    cnt_nxt  = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
    half_nxt = half_r;
    if (pop) half_nxt = 1'b0;
    else if (take) half_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      half_r   <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      cnt_r  <= cnt_nxt;
      half_r <= half_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= rec;
  end

  assign cnt = cnt_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < Q_CNT_W'(Q_DEPTH)) || pop)
    else $error("output queue overrun");

  a_half_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> (cnt_r != '0) && head.blk_v && head.st_v)
    else $error("split entry state without a matching head entry");

endmodule

// ===== design/cigar_to_aligned_blocks_unit.sv =====
`timescale 1ns / 1ps

// Alignment string to gapped alignment blocks.
// in_*  : one ASCII character per item, in_tlast on the final character.
// out_* : block items (tuser 0) with inclusive reference and match ends,
//         and one status item per string (tuser 1, tlast 1) carrying the
//         alignment type and status. Blocks of a string whose status is
//         not ok are to be dropped by the receiver.
// cfg_* : write-only registers, indexed 0 format_mode, 1 ref_start,
//         2 ref_end, 3 match_start, 4 ref_reverse, 5 match_reverse; write
//         only between strings. A start write also reloads its cursor.
// Throughput is one character per cycle while in_tready is high. A
// character goes through an input register, the parse stage and the
// combinational span check into the output queue that drives out_*.
// A character with both a block and a status gives the block item,
// then the status item. A 4-entry output queue sits in front of out_*;
// in_tready drops while the queue plus the characters in flight could
// fill it, so a stalled receiver backs up into the input without loss.
// Reset is synchronous: registers go to their defaults (format 0, starts
// and end 1, forward strands), the parser starts a new string and the
// queue is emptied.
module cigar_to_aligned_blocks_unit import cta_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // char_byte
  input  logic                  in_tlast,   // last_char
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_BITS-1:0] out_tdata,  // ref_first, ref_last, match_first,
                                            // match_last, align_type, status, pad
  output logic                  out_tuser,  // item_kind
  output logic                  out_tlast,  // last_result
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_addr,
  input  logic [31:0]           cfg_wr_data
);

  cta_cfg_t            cfg_r;
  cta_ld_t             ld;
  cta_fin_t            fin;
  cta_occ_t            occ;
  cta_rec_t            rec;
  logic                push;
  logic [Q_CNT_W-1:0]  q_cnt;
  logic                in_acc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt         <= 1'b0;
      cfg_r.ref_start   <= CFG_COORD_RST;
      cfg_r.ref_end     <= CFG_COORD_RST;
      cfg_r.match_start <= CFG_COORD_RST;
      cfg_r.ref_rev     <= 1'b0;
      cfg_r.match_rev   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_FORMAT_MODE:   cfg_r.fmt         <= cfg_wr_data[0];
        REG_REF_START:     cfg_r.ref_start   <= cfg_wr_data;
        REG_REF_END:       cfg_r.ref_end     <= cfg_wr_data;
        REG_MATCH_START:   cfg_r.match_start <= cfg_wr_data;
        REG_REF_REVERSE:   cfg_r.ref_rev     <= cfg_wr_data[0];
        REG_MATCH_REVERSE: cfg_r.match_rev   <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  assign ld.ld_ref   = cfg_wr_en && (cfg_addr == REG_REF_START);
  assign ld.ld_match = cfg_wr_en && (cfg_addr == REG_MATCH_START);
  assign ld.data     = cfg_wr_data;

  // reserve a queue slot for every character in flight
  assign in_tready = ({1'b0, q_cnt} + (Q_CNT_W+1)'(occ.in_v) + (Q_CNT_W+1)'(occ.fin_v))
                     < (Q_CNT_W+1)'(Q_DEPTH);
  assign in_acc    = in_tvalid && in_tready;

  cta_parse #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_char (in_tdata),
    .in_last (in_tlast),
    .cfg     (cfg_r),
    .ld      (ld),
    .fin_o   (fin),
    .occ_o   (occ)
  );

  cta_final u_final (
    .clk  (clk),
    .cfg  (cfg_r),
    .fin  (fin),
    .push (push),
    .rec  (rec)
  );

  cta_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .rec        (rec),
    .cnt        (q_cnt),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
